[src/frame_reference_count_table_core_assert.svh]
// ----------------------------------------------------------------------------
// Frame reference count table: assertion macros
// Shared concurrent assertion forms for the checker, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef FRAME_REFERENCE_COUNT_TABLE_CORE_ASSERT_SVH
`define FRAME_REFERENCE_COUNT_TABLE_CORE_ASSERT_SVH

// Check a consequence in the next cycle, also across reset
`define FRCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

// Check a consequence in the next cycle, abandoned while reset is high
`define FRCT_ASSERT_NEXT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/frct_pkg.sv]
// ----------------------------------------------------------------------------
// Frame reference count table: package
// Widths, request codes, payload types and sequencer types.
// ----------------------------------------------------------------------------
package frct_pkg;

  localparam int MAX_FRAMES  = 4096;
  localparam int FRAME_BYTES = 4096;
  localparam int ADDR_W      = 32;
  localparam int FRAME_SHIFT = $clog2(FRAME_BYTES);
  localparam int FRAME_NUM_W = ADDR_W - FRAME_SHIFT;
  localparam int IDX_W       = $clog2(MAX_FRAMES);
  localparam int COUNT_W     = 16;
  localparam int FCOUNT_W    = 13;
  localparam int SHARED_W    = 13;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    REQ_TAKE   = 2'd0,
    REQ_DROP   = 2'd1,
    REQ_READ   = 2'd2,
    REQ_SHARED = 2'd3
  } req_type_t;

  typedef struct packed {
    req_type_t          req_type;
    logic [ADDR_W-1:0]  byte_addr;
  } frct_req_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  ref_count;
    logic                in_range;
    logic [SHARED_W-1:0] shared_total;
  } frct_rsp_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } seq_state_t;

  typedef struct packed {
    logic             accept_ok;
    logic             finish;
    logic             clear_wr;
    logic [IDX_W-1:0] clear_idx;
  } seq_ctrl_t;

endpackage

[src/frct_ram.sv]
// ----------------------------------------------------------------------------
// Frame reference count table: count memory
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module frct_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[src/frct_upd.sv]
// ----------------------------------------------------------------------------
// Frame reference count table: count update
// Saturating take/drop of one count and the matching shared tally change.
// ----------------------------------------------------------------------------
module frct_upd (
  input  frct_pkg::req_type_t            req_type,
  input  logic [frct_pkg::COUNT_W-1:0]   count_old,
  input  logic [frct_pkg::SHARED_W-1:0]  tally_old,
  output logic [frct_pkg::COUNT_W-1:0]   count_new,
  output logic [frct_pkg::SHARED_W-1:0]  tally_new
);
  import frct_pkg::*;

  // Bump or drop the count; track crossings between one and two
  always_comb begin
    count_new = count_old;
    tally_new = tally_old;
    unique case (req_type)
      REQ_TAKE: begin
        if (count_old != COUNT_MAX) begin
          count_new = count_old + COUNT_W'(1);
          if (count_old == COUNT_W'(1)) begin
            tally_new = tally_old + SHARED_W'(1);
          end
        end
      end
      REQ_DROP: begin
        if (count_old != '0) begin
          count_new = count_old - COUNT_W'(1);
          if ((count_old == COUNT_W'(2)) && (tally_old != '0)) begin
            tally_new = tally_old - SHARED_W'(1);
          end
        end
      end
      REQ_READ, REQ_SHARED: begin
        count_new = count_old;
      end
    endcase
  end

endmodule

[src/frct_seq.sv]
// ----------------------------------------------------------------------------
// Frame reference count table: sequencer
// Clearing sweep after reset or reconfiguration, then lookup per request.
// ----------------------------------------------------------------------------
module frct_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                in_valid,
  input  logic                out_free,
  output frct_pkg::seq_ctrl_t ctrl
);
  import frct_pkg::*;

  seq_state_t       state;
  seq_state_t       state_next;
  logic [IDX_W-1:0] clear_idx;

  // Next state; a register write restarts the sweep
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clear_idx == IDX_W'(MAX_FRAMES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
    if (cfg_we) begin
      state_next = ST_CLEAR;
    end
  end

  // State and sweep pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clear_idx <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        clear_idx <= '0;
      end else if (state == ST_CLEAR) begin
        clear_idx <= clear_idx + IDX_W'(1);
      end
    end
  end

  // Control outputs
  always_comb begin
    ctrl.accept_ok = (state == ST_IDLE);
    ctrl.finish    = (state == ST_LOOKUP) && out_free;
    ctrl.clear_wr  = (state == ST_CLEAR);
    ctrl.clear_idx = clear_idx;
  end

endmodule

[src/frame_reference_count_table_core.sv]
// ----------------------------------------------------------------------------
// Frame reference count table: top level
// Saturating 16-bit reference count per physical frame, held in one RAM,
// with a running tally of frames whose count is above one.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in        in         in_valid / in_stall  frct_req_t (req_type, byte_addr)
//  out       out        out_valid/out_stall  frct_rsp_t (ref_count, in_range,
//                                             shared_total)
//  cfg       in         cfg_we               cfg_wdata (frame_count)
//
// Each request takes two cycles: acceptance, then one cycle in which the
// registered RAM read returns and the new count is written back.
// Reset and every frame_count write start a clearing pass of MAX_FRAMES
// (4096) cycles, during which in_stall stays high.
// A stalled result holds in the output register; a new request is accepted
// meanwhile and waits in lookup until the register frees up.
// ----------------------------------------------------------------------------
module frame_reference_count_table_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  frct_pkg::frct_req_t           in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output frct_pkg::frct_rsp_t           out_data,
  input  logic                          cfg_we,
  input  logic [frct_pkg::FCOUNT_W-1:0] cfg_wdata
);
  import frct_pkg::*;

  seq_ctrl_t            ctrl;
  logic                 out_free;
  logic                 accept;
  logic [FRAME_NUM_W-1:0] pfn;
  logic [FCOUNT_W-1:0]  eff_frames;
  logic                 in_hit;

  logic [FCOUNT_W-1:0]  frame_count;
  logic [SHARED_W-1:0]  tally;
  req_type_t            req_type_q;
  logic [IDX_W-1:0]     idx_q;
  logic                 hit_q;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [COUNT_W-1:0]   ram_wdata;
  logic [IDX_W-1:0]     ram_raddr;
  logic [COUNT_W-1:0]   ram_rdata;

  logic [COUNT_W-1:0]   count_new;
  logic [SHARED_W-1:0]  tally_new;

  // Handshake
  assign out_free = !out_valid || !out_stall;
  assign in_stall = !ctrl.accept_ok;
  assign accept   = in_valid && ctrl.accept_ok;

  // Frame number and range check against the capped frame count
  assign pfn        = in_data.byte_addr[ADDR_W-1:FRAME_SHIFT];
  assign eff_frames = (32'(frame_count) > 32'(MAX_FRAMES)) ? FCOUNT_W'(MAX_FRAMES)
                                                         : frame_count;
  assign in_hit     = pfn < FRAME_NUM_W'(eff_frames);

  frct_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .in_valid (in_valid),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= '0;
    end else if (cfg_we) begin
      frame_count <= cfg_wdata;
    end
  end

  // Capture the accepted request
  always_ff @(posedge clk) begin
    if (accept) begin
      req_type_q <= in_data.req_type;
      idx_q      <= pfn[IDX_W-1:0];
      hit_q      <= in_hit;
    end
  end

  // Read the new frame on acceptance, else keep rereading the held one
  assign ram_raddr = accept ? pfn[IDX_W-1:0] : idx_q;

  frct_upd u_upd (
    .req_type  (req_type_q),
    .count_old (ram_rdata),
    .tally_old (tally),
    .count_new (count_new),
    .tally_new (tally_new)
  );

  // Write back the updated count, or zero during the sweep
  assign ram_we    = ctrl.clear_wr || (ctrl.finish && hit_q);
  assign ram_waddr = ctrl.clear_wr ? ctrl.clear_idx : idx_q;
  assign ram_wdata = ctrl.clear_wr ? '0 : count_new;

  frct_ram #(
    .DEPTH (MAX_FRAMES),
    .WIDTH (COUNT_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared tally: clear with the table, advance on an in-range update
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      tally <= '0;
    end else if (ctrl.finish && hit_q) begin
      tally <= tally_new;
    end
  end

  // Output register: load on finish, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= ctrl.finish || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      out_data.ref_count    <= hit_q ? count_new : '0;
      out_data.in_range     <= hit_q;
      out_data.shared_total <= hit_q ? tally_new : tally;
    end
  end

endmodule

[src/frct_checker.sv]
// ----------------------------------------------------------------------------
// Frame reference count table: port checker
// Watches the top-level ports for sweep, occupancy and output hold rules.
// ----------------------------------------------------------------------------
`include "frame_reference_count_table_core_assert.svh"

module frct_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input frct_pkg::frct_rsp_t out_data,
  input logic                cfg_we
);

  logic out_held;

  assign out_held = out_valid && out_stall;

  // Reset and reconfiguration both start the clearing sweep
  `FRCT_ASSERT_NEXT(a_rst_sweep, rst, in_stall, "no sweep after reset")
  `FRCT_ASSERT_NEXT(a_cfg_sweep, cfg_we, in_stall, "no sweep after config write")

  // One request in flight at a time
  `FRCT_ASSERT_NEXT_RST(a_one_in_flight, in_valid && !in_stall, in_stall, "second request taken")

  // A stalled result stays put
  `FRCT_ASSERT_NEXT_RST(a_out_hold, out_held, out_valid && $stable(out_data), "result moved")

endmodule

bind frame_reference_count_table_core frct_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .cfg_we    (cfg_we)
);

[tb/frame_reference_count_table_core_tb.sv]
// ----------------------------------------------------------------------------
// Frame reference count table: testbench
// Drives take, drop, read and shared-total requests through the
// valid/stall channels and checks every response against a local model
// of the count table and the shared tally. The run covers an uninitialised
// table, small tables, a frame count above capacity and the last frame.
// ----------------------------------------------------------------------------
module frame_reference_count_table_core_tb;
  import frct_pkg::*;

  logic                clk;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  frct_req_t           in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  frct_rsp_t           out_data;
  logic                cfg_we    = 1'b0;
  logic [FCOUNT_W-1:0] cfg_wdata = '0;

  // Local copy of the table state
  logic [COUNT_W-1:0]  frame_refs [MAX_FRAMES];
  logic [SHARED_W-1:0] model_tally;
  logic [FCOUNT_W-1:0] frames_set;

  frct_req_t   outgoing_reqs[$];
  frct_rsp_t   due_rsps[$];
  bit          burst;
  bit          failed;
  logic        req_taken = 1'b0;
  logic        rsp_taken = 1'b0;
  int unsigned send_wait;
  int unsigned stall_wait;

  frame_reference_count_table_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Bound the run well beyond the slowest legal completion
  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

  function automatic int unsigned tracked_frames();
    return (frames_set > MAX_FRAMES) ? MAX_FRAMES : frames_set;
  endfunction

  function automatic void clear_counts();
    foreach (frame_refs[i]) frame_refs[i] = '0;
    model_tally = '0;
  endfunction

  // Update the local table for one request and queue its response
  function automatic void apply_request(frct_req_t r);
    logic [FRAME_NUM_W-1:0] frame;
    logic [COUNT_W-1:0]     cnt;
    frct_rsp_t              rsp;
    frame        = r.byte_addr[ADDR_W-1:FRAME_SHIFT];
    cnt          = '0;
    rsp.in_range = (frame < tracked_frames());
    if (rsp.in_range) begin
      cnt = frame_refs[frame[IDX_W-1:0]];
      case (r.req_type)
        REQ_TAKE: begin
          if (cnt != COUNT_MAX) begin
            cnt++;
            if (cnt == 2) model_tally++;
          end
        end
        REQ_DROP: begin
          if (cnt != 0) begin
            if (cnt == 2 && model_tally != 0) model_tally--;
            cnt--;
          end
        end
        default: ;
      endcase
      frame_refs[frame[IDX_W-1:0]] = cnt;
    end
    rsp.ref_count    = cnt;
    rsp.shared_total = model_tally;
    due_rsps.push_back(rsp);
  endfunction

  // Record each accepted request in the model
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      apply_request(in_data);
      req_taken <= 1'b1;
    end else begin
      req_taken <= 1'b0;
    end
  end

  // Compare each accepted response with the oldest one due
  always @(posedge clk) begin : check_rsp
    frct_rsp_t want;
    if (!rst && out_valid && !out_stall) begin
      rsp_taken <= 1'b1;
      if (due_rsps.size() == 0) begin
        $display("%0t: unexpected response %h", $time, out_data);
        failed = 1'b1;
      end else begin
        want = due_rsps.pop_front();
        if (out_data.ref_count !== want.ref_count) begin
          $display("%0t: ref_count expected %0d actual %0d",
                   $time, want.ref_count, out_data.ref_count);
          failed = 1'b1;
        end
        if (out_data.in_range !== want.in_range) begin
          $display("%0t: in_range expected %0d actual %0d",
                   $time, want.in_range, out_data.in_range);
          failed = 1'b1;
        end
        if (out_data.shared_total !== want.shared_total) begin
          $display("%0t: shared_total expected %0d actual %0d",
                   $time, want.shared_total, out_data.shared_total);
          failed = 1'b1;
        end
      end
    end else begin
      rsp_taken <= 1'b0;
    end
  end

  // Request driver: hold a request until taken, then a random idle wait, which may be none
  always @(negedge clk) begin
    if (!rst && (!in_valid || req_taken)) begin
      if (send_wait != 0) begin
        send_wait--;
        in_valid <= 1'b0;
      end else if (outgoing_reqs.size() != 0) begin
        in_data   <= outgoing_reqs.pop_front();
        in_valid  <= 1'b1;
        send_wait = burst ? 0 : $urandom_range(0, 15);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Response stall: draw a fresh stall after every response taken
  always @(negedge clk) begin
    if (rsp_taken) stall_wait = burst ? 0 : $urandom_range(0, 15);
    if (stall_wait != 0) begin
      out_stall <= 1'b1;
      stall_wait--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic logic [ADDR_W-1:0] addr_of(int unsigned frame);
    logic [FRAME_NUM_W-1:0] fn;
    logic [FRAME_SHIFT-1:0] offs;
    fn   = FRAME_NUM_W'(frame);
    offs = FRAME_SHIFT'($urandom_range(0, FRAME_BYTES - 1));
    return {fn, offs};
  endfunction

  function automatic void queue_req(req_type_t t, logic [ADDR_W-1:0] a);
    frct_req_t r;
    r.req_type  = t;
    r.byte_addr = a;
    outgoing_reqs.push_back(r);
  endfunction

  // Random request: mostly a few hot frames so counts cross one and two
  function automatic void queue_random_req();
    int unsigned pick;
    int unsigned eff;
    req_type_t   t;
    logic [ADDR_W-1:0] a;
    pick = $urandom_range(0, 99);
    if (pick < 40) t = REQ_TAKE;
    else if (pick < 65) t = REQ_DROP;
    else if (pick < 80) t = REQ_READ;
    else t = REQ_SHARED;
    eff  = tracked_frames();
    pick = $urandom_range(0, 99);
    if (eff != 0 && pick < 60) begin
      a = addr_of($urandom_range(0, (eff < 6) ? eff - 1 : 5));
    end else if (eff != 0 && pick < 75) begin
      a = addr_of($urandom_range(0, eff - 1));
    end else if (pick < 85) begin
      a = addr_of(eff + $urandom_range(0, 2));
    end else begin
      a = $urandom();
    end
    queue_req(t, a);
  endfunction

  // Wait until no request is pending and the block is quiet
  task automatic settle();
    @(negedge clk);
    while (outgoing_reqs.size() != 0 || due_rsps.size() != 0 || in_valid || in_stall)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_frames(logic [FCOUNT_W-1:0] v);
    settle();
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we     <= 1'b0;
    frames_set = v;
    clear_counts();
  endtask

  initial begin : stimulus
    logic [FCOUNT_W-1:0] settings [10];
    frames_set = '0;
    clear_counts();
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Uninitialised table: every request out of range
    queue_req(REQ_TAKE,   32'h0000_0000);
    queue_req(REQ_DROP,   32'h0000_0000);
    queue_req(REQ_READ,   32'hFFFF_FFFF);
    queue_req(REQ_SHARED, 32'h1234_5678);

    // Three frames: sharing, drop floor, range edge
    set_frames(13'd3);
    queue_req(REQ_TAKE,   32'h0000_0000);
    queue_req(REQ_TAKE,   32'h0000_0FFF);
    queue_req(REQ_TAKE,   32'h0000_0100);
    queue_req(REQ_READ,   32'h0000_0000);
    queue_req(REQ_TAKE,   32'h0000_1000);
    queue_req(REQ_DROP,   32'h0000_1000);
    queue_req(REQ_DROP,   32'h0000_1FFF);
    queue_req(REQ_SHARED, 32'h0000_2FFF);
    queue_req(REQ_SHARED, 32'h0000_3000);
    queue_req(REQ_TAKE,   32'h0000_3000);
    queue_req(REQ_DROP,   32'hFFFF_FFFF);
    queue_req(REQ_READ,   32'h8000_0000);
    queue_req(REQ_DROP,   32'h0000_0000);
    queue_req(REQ_DROP,   32'h0000_0000);
    queue_req(REQ_TAKE,   32'h0000_2000);
    queue_req(REQ_DROP,   32'h0000_0000);

    // Frame count above capacity, then hit the last frame back to back
    set_frames(13'd8191);
    queue_req(REQ_TAKE, 32'h0100_0000);
    queue_req(REQ_TAKE, 32'h00FF_F000);
    settle();
    burst = 1'b1;
    repeat (3) queue_req(REQ_TAKE, 32'h00FF_FABC);
    queue_req(REQ_READ,   32'h00FF_F000);
    queue_req(REQ_DROP,   32'h00FF_F000);
    queue_req(REQ_TAKE,   32'h00FF_F000);
    queue_req(REQ_SHARED, 32'h00FF_FFFF);
    settle();
    burst = 1'b0;

    // Random phases across several table sizes
    settings = '{13'd1, 13'd2, 13'd5, 13'd16, 13'd4096, 13'd0, 13'd8191,
                 13'd4095, 13'd3, 13'd0};
    settings[9] = FCOUNT_W'($urandom_range(1, 8191));
    foreach (settings[p]) begin
      set_frames(settings[p]);
      burst = (p == 3);
      repeat (185) queue_random_req();
    end

    // Drain, then allow for late or stray responses
    settle();
    repeat (10) @(negedge clk);
    if (due_rsps.size() != 0) begin
      $display("%0t: %0d responses never arrived", $time, due_rsps.size());
      failed = 1'b1;
    end
    if (!failed) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/frct_pkg.sv
src/frct_ram.sv
src/frct_upd.sv
src/frct_seq.sv
src/frame_reference_count_table_core.sv
src/frct_checker.sv
tb/frame_reference_count_table_core_tb.sv
